// ===== rtl/fct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants of the frustum cull tester
// Command codes, controller states, widths of the fixed-point datapath and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int CoordW  = 32;  // Q16.16 coordinates and offsets
    localparam int HalfW   = 31;  // Q15.16 unsigned extents
    localparam int NormW   = 18;  // Q2.16 normals
    localparam int ProdW   = 50;  // normal times coordinate, Q18.32
    localparam int LimPW   = 49;  // |normal| times extent
    localparam int DistW   = 54;  // summed distance and limit, Q.32
    localparam int FracW   = 16;  // Q16.16 fraction bits
    localparam int OutDW   = 36;  // Q20.16 max distance
    localparam int IdxW    = 3;   // plane_index field

    typedef enum logic [1:0] {
        CMD_BOX    = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_POINT  = 2'd2,
        CMD_LOAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic issue;     // present one plane to the pipeline
        logic first;     // issued plane is the first of the query
        logic last;      // issued plane is the last of the query
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fin;       // last plane folds into the accumulator this cycle
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/fct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_ctrl: sequencer of the frustum cull tester
// Accepts commands, steps one plane per cycle into the datapath, waits for
// the pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module fct_ctrl
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int PW         = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_cmd,
    input  wire t_dp_stat      i_stat,
    output logic               o_in_stall,
    output t_dp_cmd            o_cmd,
    output logic [PW-1:0]      o_plane,
    output t_state             o_state
);

    t_state        r_state, n_state;
    logic [PW-1:0] r_cnt, n_cnt;
    logic          accept;
    logic          at_last;

    assign at_last = (r_cnt == PW'(NUM_PLANES - 1));
    assign accept  = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_in_stall     = 1'b1;
        o_cmd          = '0;
        o_cmd.accept   = accept;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
                if (accept && (t_cmd'(i_cmd) != CMD_LOAD)) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_cnt == '0);
                o_cmd.last  = at_last;
                if (at_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WAIT: begin
                if (i_stat.fin) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the previous result has left
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_plane = r_cnt;
    assign o_state = r_state;

endmodule
`default_nettype wire

// ===== rtl/fct_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_dp: plane store and distance pipeline
// Holds the planes and the query, multiplies one plane per cycle, sums,
// compares and folds into the pass flag and maximum distance.
// ----------------------------------------------------------------------------
module fct_dp
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int PW         = 3
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [PW-1:0]            i_plane,
    input  wire logic [1:0]               i_op,
    input  wire logic signed [CoordW-1:0] i_center_x,
    input  wire logic signed [CoordW-1:0] i_center_y,
    input  wire logic signed [CoordW-1:0] i_center_z,
    input  wire logic [HalfW-1:0]         i_half_x,
    input  wire logic [HalfW-1:0]         i_half_y,
    input  wire logic [HalfW-1:0]         i_half_z,
    input  wire logic [IdxW-1:0]          i_plane_index,
    input  wire logic signed [NormW-1:0]  i_load_nx,
    input  wire logic signed [NormW-1:0]  i_load_ny,
    input  wire logic signed [NormW-1:0]  i_load_nz,
    input  wire logic signed [CoordW-1:0] i_load_offset,
    input  wire logic                     i_out_stall,
    output t_dp_stat                      o_stat,
    output logic                          o_out_valid,
    output logic                          o_inside_res,
    output logic signed [OutDW-1:0]       o_max_distance
);

    // plane store
    logic signed [NormW-1:0]  r_nx  [NUM_PLANES];
    logic signed [NormW-1:0]  r_ny  [NUM_PLANES];
    logic signed [NormW-1:0]  r_nz  [NUM_PLANES];
    logic signed [CoordW-1:0] r_off [NUM_PLANES];

    // query
    t_cmd                     r_op;
    logic signed [CoordW-1:0] r_cx, r_cy, r_cz;
    logic [HalfW-1:0]         r_hx, r_hy, r_hz;

    // stage 1: products
    logic                     r_v1, r_first1, r_last1;
    logic signed [ProdW-1:0]  r_px, r_py, r_pz;
    logic [LimPW-1:0]         r_lx, r_ly, r_lz;
    logic signed [CoordW-1:0] r_off1;

    // stage 2: sums
    logic                     r_v2, r_first2, r_last2;
    logic signed [DistW-1:0]  r_d, r_lim;

    // stage 3: accumulator
    logic                     r_pass;
    logic signed [DistW-1:0]  r_best;

    logic                     load_we;
    logic signed [NormW-1:0]  sel_nx, sel_ny, sel_nz;
    logic [NormW-1:0]         abs_nx, abs_ny, abs_nz;
    logic signed [DistW-1:0]  best_sh;

    assign load_we = i_cmd.accept && (t_cmd'(i_op) == CMD_LOAD) &&
                     ({1'b0, i_plane_index} < (IdxW + 1)'(NUM_PLANES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PLANES; k++) begin
                r_nx[k]  <= '0;
                r_ny[k]  <= '0;
                r_nz[k]  <= '0;
                r_off[k] <= '0;
            end
        end else if (load_we) begin
            r_nx[i_plane_index[PW-1:0]]  <= i_load_nx;
            r_ny[i_plane_index[PW-1:0]]  <= i_load_ny;
            r_nz[i_plane_index[PW-1:0]]  <= i_load_nz;
            r_off[i_plane_index[PW-1:0]] <= i_load_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= t_cmd'(i_op);
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_cz <= i_center_z;
            r_hx <= i_half_x;
            r_hy <= i_half_y;
            r_hz <= i_half_z;
        end
    end

    assign sel_nx = r_nx[i_plane];
    assign sel_ny = r_ny[i_plane];
    assign sel_nz = r_nz[i_plane];
    // most negative normal maps to 2^17, which the unsigned width still holds
    assign abs_nx = sel_nx[NormW-1] ? NormW'(-sel_nx) : NormW'(sel_nx);
    assign abs_ny = sel_ny[NormW-1] ? NormW'(-sel_ny) : NormW'(sel_ny);
    assign abs_nz = sel_nz[NormW-1] ? NormW'(-sel_nz) : NormW'(sel_nz);

    always_ff @(posedge i_clk) begin
        r_px   <= ProdW'(sel_nx) * ProdW'(r_cx);
        r_py   <= ProdW'(sel_ny) * ProdW'(r_cy);
        r_pz   <= ProdW'(sel_nz) * ProdW'(r_cz);
        r_lx   <= LimPW'(abs_nx) * LimPW'(r_hx);
        r_ly   <= LimPW'(abs_ny) * LimPW'(r_hy);
        r_lz   <= LimPW'(abs_nz) * LimPW'(r_hz);
        r_off1 <= r_off[i_plane];
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last;
        r_d <= DistW'(r_px) + DistW'(r_py) + DistW'(r_pz) + (DistW'(r_off1) <<< FracW);
        if (r_op == CMD_BOX) begin
            r_lim <= $signed(DistW'(r_lx) + DistW'(r_ly) + DistW'(r_lz));
        end else begin
            r_lim <= $signed(DistW'(r_hx) << FracW);
        end
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        if (r_v2) begin
            r_pass <= (r_first2 || r_pass) && !(r_d > r_lim);
            if (r_first2 || (r_d > r_best)) begin
                r_best <= r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // floor to Q20.16
    assign best_sh = r_best >>> FracW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_op == CMD_POINT) begin
                o_inside_res   <= 1'b0;
                o_max_distance <= best_sh[OutDW-1:0];
            end else begin
                o_inside_res   <= r_pass;
                o_max_distance <= '0;
            end
        end
    end

    assign o_stat.fin      = r_v2 && r_last2;
    assign o_stat.out_free = !o_out_valid || !i_out_stall;

endmodule
`default_nettype wire

// ===== rtl/frustum_cull_tester_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_tester_unit: plane/box/sphere/point frustum test
// Stores NUM_PLANES planes and tests boxes and spheres against them, or
// returns the largest signed plane distance of a point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_cmd, centers, halves, load
//  out     | output    | o_out_valid/i_out_stall | o_inside_res, o_max_distance
//
//  A load writes its plane at the transfer and gives no result. A query steps
//  one plane per cycle into the shared multiply/sum/compare pipeline, waits for
//  it to drain and for the output register to be free, then hands its result
//  off; the input stays closed from its transfer until that hand-off.
//  Reset clears all planes to zero; control and valid flags clear with it.
//  A held result blocks only the next query's hand-off, not its transfer in.
// ----------------------------------------------------------------------------
module frustum_cull_tester_unit
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_cmd,
    input  wire logic signed [CoordW-1:0] i_center_x,
    input  wire logic signed [CoordW-1:0] i_center_y,
    input  wire logic signed [CoordW-1:0] i_center_z,
    input  wire logic [HalfW-1:0]         i_half_x,
    input  wire logic [HalfW-1:0]         i_half_y,
    input  wire logic [HalfW-1:0]         i_half_z,
    input  wire logic [IdxW-1:0]          i_plane_index,
    input  wire logic signed [NormW-1:0]  i_load_nx,
    input  wire logic signed [NormW-1:0]  i_load_ny,
    input  wire logic signed [NormW-1:0]  i_load_nz,
    input  wire logic signed [CoordW-1:0] i_load_offset,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_inside_res,
    output logic signed [OutDW-1:0]       o_max_distance
);

    // plane counter width, at least one bit
    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [PW-1:0] plane;
    t_state        state;

    fct_ctrl #(
        .NUM_PLANES (NUM_PLANES),
        .PW         (PW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .o_plane    (plane),
        .o_state    (state)
    );

    fct_dp #(
        .NUM_PLANES (NUM_PLANES),
        .PW         (PW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_plane        (plane),
        .i_op           (i_cmd),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_center_z     (i_center_z),
        .i_half_x       (i_half_x),
        .i_half_y       (i_half_y),
        .i_half_z       (i_half_z),
        .i_plane_index  (i_plane_index),
        .i_load_nx      (i_load_nx),
        .i_load_ny      (i_load_ny),
        .i_load_nz      (i_load_nz),
        .i_load_offset  (i_load_offset),
        .i_out_stall    (i_out_stall),
        .o_stat         (dp_stat),
        .o_out_valid    (o_out_valid),
        .o_inside_res   (o_inside_res),
        .o_max_distance (o_max_distance)
    );

`ifndef NO_ASSERTIONS
    // a query transfer closes the input until its result is handed off
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_cmd != CMD_LOAD)) |=> o_in_stall)
        else $error("input left open after a query transfer");

    // the last plane only drains while the controller waits for it
    a_fin_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.fin |-> (state == ST_WAIT))
        else $error("pipeline finished outside the wait state");

    // a load never produces a result
    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_cmd == CMD_LOAD) && !o_out_valid)
        |=> !o_out_valid)
        else $error("load produced a result");
`endif

endmodule
`default_nettype wire
